// ===== rtl/query_key_value_lookup_assert.svh =====
// Assertion macros for the query key/value lookup block.
`ifndef QUERY_KEY_VALUE_LOOKUP_ASSERT_SVH
`define QUERY_KEY_VALUE_LOOKUP_ASSERT_SVH
`ifndef ASSERT_OFF
// Checks an implication on every clock edge outside reset.
`define KVL_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("query_key_value_lookup assertion failed");
// Checks that a condition holds in the cycle after its trigger.
`define KVL_ASSERT_NEXT(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("query_key_value_lookup assertion failed");
`else
`define KVL_ASSERT(lbl, prop)
`define KVL_ASSERT_NEXT(lbl, trig, cond)
`endif
`endif

// ===== rtl/kvl_pkg.sv =====
// Shared types, codes and helpers for the query key/value lookup block.
package kvl_pkg;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;
	localparam logic [1:0] ACT_END    = 2'd3;

	localparam logic [7:0] ASCII_AMP     = 8'h26;
	localparam logic [7:0] ASCII_EQ      = 8'h3D;
	localparam logic [7:0] ASCII_UPPER_A = 8'h41;
	localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET   = 8'd32;

	localparam logic [15:0] POS_MAX = 16'hFFFF;

	typedef struct packed {
		logic        found;
		logic        has_value;
		logic [15:0] value_offset;
		logic [15:0] value_length;
		logic        query_too_long;
	} kvl_res_t;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c inside {[ASCII_UPPER_A:ASCII_UPPER_Z]}) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

// ===== rtl/kvl_if.sv =====
// Valid/ready channel interfaces for query items and lookup results.
interface kvl_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] data_byte;

	modport source (output valid, output action, output data_byte, input ready);
	modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface kvl_out_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic        has_value;
	logic [15:0] value_offset;
	logic [15:0] value_length;
	logic        query_too_long;

	modport source (output valid, output found, output has_value, output value_offset,
		output value_length, output query_too_long, input ready);
	modport sink (input valid, input found, input has_value, input value_offset,
		input value_length, input query_too_long, output ready);
endinterface

// ===== rtl/kvl_key_mem.sv =====
// Search key byte store: one write port, one registered read port.
module kvl_key_mem #(
	parameter int DEPTH = 255,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [0:DEPTH-1];
	logic [7:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Forward the byte being written when it lands on the read address.
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_q <= wr_data;
		end else begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ===== rtl/kvl_scanner.sv =====
// Pair scanner: key length, match state, position counting and result forming.
module kvl_scanner import kvl_pkg::*; #(
	parameter int KEY_MAX = 255,
	parameter int AW      = 8,
	parameter int LEN_W   = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [1:0]    action,
	input  logic [7:0]    data_byte,
	input  logic [7:0]    key_byte,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [7:0]    wr_data,
	output logic [AW-1:0] rd_addr,
	output kvl_res_t      res
);

	localparam logic [1:0] PH_KEY   = 2'd0;
	localparam logic [1:0] PH_SKIP  = 2'd1;
	localparam logic [1:0] PH_VALUE = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	localparam logic [LEN_W-1:0] KMAX = LEN_W'(KEY_MAX);

	logic [LEN_W-1:0] len_q, len_n;
	logic [1:0]       phase_q, phase_n;
	logic [LEN_W-1:0] kp_q, kp_n;
	logic             still_q, still_n;
	logic             found_q, found_n;
	logic             hv_q, hv_n;
	logic [15:0]      start_q, start_n;
	logic [15:0]      cnt_q, cnt_n;
	logic [15:0]      qpos_q, qpos_n;
	logic             ovf_q, ovf_n;

	logic key_match;
	logic last_hit;
	logic restart;

	assign key_match = still_q && (len_q <= KMAX) && (kp_q == len_q);
	assign last_hit  = (phase_q == PH_KEY) && (kp_q != '0) && key_match;

	always_comb begin
		len_n   = len_q;
		phase_n = phase_q;
		kp_n    = kp_q;
		still_n = still_q;
		found_n = found_q;
		hv_n    = hv_q;
		start_n = start_q;
		cnt_n   = cnt_q;
		qpos_n  = qpos_q;
		ovf_n   = ovf_q;
		restart = 1'b0;
		if (go) begin
			case (action)
				ACT_CLEAR: begin
					len_n   = '0;
					restart = 1'b1;
				end
				ACT_APPEND: begin
					if (len_q <= KMAX) begin
						len_n = len_q + 1'b1;
					end
					restart = 1'b1;
				end
				ACT_QUERY: begin
					if (qpos_q == POS_MAX) begin
						ovf_n = 1'b1;
					end else begin
						qpos_n = qpos_q + 16'd1;
					end
					case (phase_q)
						PH_KEY: begin
							if (data_byte == ASCII_AMP) begin
								if (key_match) begin
									found_n = 1'b1;
									hv_n    = 1'b0;
									start_n = '0;
									cnt_n   = '0;
									phase_n = PH_DONE;
								end else begin
									kp_n    = '0;
									still_n = 1'b1;
								end
							end else if (data_byte == ASCII_EQ) begin
								if (key_match) begin
									found_n = 1'b1;
									hv_n    = 1'b1;
									start_n = (qpos_q == POS_MAX) ? POS_MAX : qpos_q + 16'd1;
									cnt_n   = '0;
									phase_n = PH_VALUE;
								end else begin
									phase_n = PH_SKIP;
								end
							end else begin
								if ((kp_q < len_q) && (kp_q < KMAX)) begin
									if (fold_case(data_byte) != fold_case(key_byte)) begin
										still_n = 1'b0;
									end
								end else begin
									still_n = 1'b0;
								end
								if (kp_q <= KMAX) begin
									kp_n = kp_q + 1'b1;
								end
							end
						end
						PH_SKIP: begin
							if (data_byte == ASCII_AMP) begin
								phase_n = PH_KEY;
								kp_n    = '0;
								still_n = 1'b1;
							end
						end
						PH_VALUE: begin
							if (data_byte == ASCII_AMP) begin
								phase_n = PH_DONE;
							end else if (cnt_q != POS_MAX) begin
								cnt_n = cnt_q + 16'd1;
							end
						end
						default: begin
						end
					endcase
				end
				ACT_END: begin
					restart = 1'b1;
				end
				default: begin
				end
			endcase
			if (restart) begin
				phase_n = PH_KEY;
				kp_n    = '0;
				still_n = 1'b1;
				found_n = 1'b0;
				hv_n    = 1'b0;
				start_n = '0;
				cnt_n   = '0;
				qpos_n  = '0;
				ovf_n   = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			phase_q <= PH_KEY;
			kp_q    <= '0;
			still_q <= 1'b1;
			found_q <= 1'b0;
			hv_q    <= 1'b0;
			start_q <= '0;
			cnt_q   <= '0;
			qpos_q  <= '0;
			ovf_q   <= 1'b0;
		end else begin
			len_q   <= len_n;
			phase_q <= phase_n;
			kp_q    <= kp_n;
			still_q <= still_n;
			found_q <= found_n;
			hv_q    <= hv_n;
			start_q <= start_n;
			cnt_q   <= cnt_n;
			qpos_q  <= qpos_n;
			ovf_q   <= ovf_n;
		end
	end

	assign wr_en   = go && (action == ACT_APPEND) && (len_q < KMAX);
	assign wr_addr = len_q[AW-1:0];
	assign wr_data = data_byte;
	// Prefetch the key byte for the next key position.
	assign rd_addr = kp_n[AW-1:0];

	// A match of a trailing pair without '=' only happens when nothing matched before.
	always_comb begin
		res.found          = found_q || last_hit;
		res.has_value      = found_q && hv_q;
		res.value_offset   = (found_q && hv_q) ? start_q : '0;
		res.value_length   = (found_q && hv_q) ? cnt_q : '0;
		res.query_too_long = ovf_q;
	end

endmodule

// ===== rtl/query_key_value_lookup.sv =====
// Query key/value lookup takes one transfer per clock on the query channel: clear
// the search key, append a key byte, give a query byte, or mark the end of the
// query. Items are taken at one per cycle, back to back, but for the stall below; the rate is
// set by the single compare of each query byte against the key byte that the
// key memory read port has prefetched for the current key position. An
// end-of-query item raises result valid once it leaves the input register, held in a
// result register so that new items keep flowing while it waits; only a further
// end-of-query item stalls in the input register while that result is unclaimed.
// Keys are matched without regard to ASCII case; a key longer than KEY_MAX never
// matches.
module query_key_value_lookup import kvl_pkg::*; #(
	parameter int KEY_MAX = 255
) (
	input  logic              clk,
	input  logic              arst_n,
	kvl_in_if.sink            query,
	kvl_out_if.source         result
);

`include "query_key_value_lookup_assert.svh"

	localparam int AW    = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam int LEN_W = $clog2(KEY_MAX + 2);

	logic       s1_valid_q;
	logic [1:0] s1_action_q;
	logic [7:0] s1_byte_q;
	logic       s1_go;

	logic       res_valid_q;
	kvl_res_t   res_q;
	kvl_res_t   res_d;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic [AW-1:0] rd_addr;
	logic [7:0]    key_byte;

	// Hold an end-of-query item only while the previous result is still unclaimed.
	assign s1_go = s1_valid_q && ((s1_action_q != ACT_END) || !res_valid_q || result.ready);
	assign query.ready = !s1_valid_q || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (query.valid && query.ready) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (query.valid && query.ready) begin
			s1_action_q <= query.action;
			s1_byte_q   <= query.data_byte;
		end
	end

	kvl_key_mem #(
		.DEPTH (KEY_MAX),
		.AW    (AW)
	) u_key_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (key_byte)
	);

	kvl_scanner #(
		.KEY_MAX (KEY_MAX),
		.AW      (AW),
		.LEN_W   (LEN_W)
	) u_scanner (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (s1_go),
		.action    (s1_action_q),
		.data_byte (s1_byte_q),
		.key_byte  (key_byte),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr   (rd_addr),
		.res       (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_go && (s1_action_q == ACT_END)) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && (s1_action_q == ACT_END)) begin
			res_q <= res_d;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.found          = res_q.found;
	assign result.has_value      = res_q.has_value;
	assign result.value_offset   = res_q.value_offset;
	assign result.value_length   = res_q.value_length;
	assign result.query_too_long = res_q.query_too_long;

	`KVL_ASSERT(a_res_from_end,
		$rose(res_valid_q) |-> $past(s1_valid_q && (s1_action_q == ACT_END)))
	`KVL_ASSERT(a_no_value_when_missed,
		(res_valid_q && !res_q.found) |-> (!res_q.has_value &&
		(res_q.value_offset == 16'd0) && (res_q.value_length == 16'd0)))
	`KVL_ASSERT(a_stall_blocks_input, (s1_valid_q && !s1_go) |-> !query.ready)
	`KVL_ASSERT_NEXT(a_result_loaded, s1_go && (s1_action_q == ACT_END), res_valid_q)

endmodule
